// ----- sv/msp_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// msp_pkg
// Shared types, codes and constants of the sensor poll master.
// ----------------------------------------------------------------------------
package msp_pkg;

  localparam int unsigned REPLY_LENGTH_DEF = 11;
  localparam int unsigned PARSE_BYTES      = 9;   // header (3) + three words (6)
  localparam int unsigned HDR_BYTES        = 3;
  localparam int unsigned FRAME_LEN        = 8;
  localparam int unsigned BEAT_W           = $clog2(FRAME_LEN);
  localparam int unsigned SWEEP_W          = $clog2(PARSE_BYTES + 1);
  localparam int unsigned PADDR_W          = 3;

  localparam logic [15:0] TIMEOUT_RESET = 16'd500;

  // Event codes
  localparam logic [2:0] FUNC_TICK    = 3'd0;
  localparam logic [2:0] FUNC_REQUEST = 3'd1;
  localparam logic [2:0] FUNC_BYTE    = 3'd2;
  localparam logic [2:0] FUNC_STATUS  = 3'd3;
  localparam logic [2:0] FUNC_RESTART = 3'd4;

  // Register index, taken from paddr bit 2
  localparam logic REG_TIMEOUT = 1'b0;

  // Reply header
  localparam logic [7:0] HDR_ADDR  = 8'h01;
  localparam logic [7:0] HDR_FUNC  = 8'h03;
  localparam logic [7:0] HDR_BCNT  = 8'h06;

  typedef struct packed {
    logic [2:0] func;
    logic [7:0] rx_byte;
    logic       tx_refused;
  } in_item_t;

  typedef struct packed {
    logic        tx_valid;
    logic [7:0]  tx_byte;
    logic        last;
    logic [2:0]  fsm_state;
    logic        data_ok;
    logic [15:0] humidity_tenths;
    logic [15:0] temperature_tenths;
    logic [15:0] conductivity;
  } out_item_t;

  // One queued result descriptor; a burst expands into the request frame
  typedef struct packed {
    logic             burst;
    logic [2:0]       fsm_state;
    logic             data_ok;
    logic [2:0][15:0] words;
  } res_desc_t;

  // Status of the reply sweep
  typedef struct packed {
    logic             done;
    logic             hdr_ok;
    logic [2:0][15:0] words;
  } reply_sum_t;

  function automatic logic [7:0] frame_byte(input logic [BEAT_W-1:0] idx);
    logic [7:0] b;
    case (idx)
      3'd0:    b = 8'h01;
      3'd1:    b = 8'h03;
      3'd2:    b = 8'h00;
      3'd3:    b = 8'h00;
      3'd4:    b = 8'h00;
      3'd5:    b = 8'h03;
      3'd6:    b = 8'h05;
      3'd7:    b = 8'hCB;
      default: b = 8'h00;
    endcase
    return b;
  endfunction

  function automatic logic [7:0] hdr_byte(input logic [SWEEP_W-1:0] idx);
    logic [7:0] b;
    case (idx)
      4'd0:    b = HDR_ADDR;
      4'd1:    b = HDR_FUNC;
      default: b = HDR_BCNT;
    endcase
    return b;
  endfunction

endpackage
`default_nettype wire

// ----- sv/msp_ram.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// msp_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module msp_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output      logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule
`default_nettype wire

// ----- sv/msp_reply.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// msp_reply
// Reply byte buffer and header/word sweep over it once the reply is full.
// ----------------------------------------------------------------------------
module msp_reply #(
  parameter int unsigned REPLY_LENGTH = 11
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            wr_en_i,
  input  wire logic [$clog2(REPLY_LENGTH)-1:0] wr_addr_i,
  input  wire logic [7:0]                      wr_data_i,
  input  wire logic                            start_i,
  input  wire logic                            abort_i,
  output      msp_pkg::reply_sum_t             sum_o
);
  import msp_pkg::*;

  localparam int unsigned AW = $clog2(REPLY_LENGTH);

  logic               busy_q, busy_d;
  logic               done_q, done_d;
  logic [SWEEP_W-1:0] iss_q, iss_d;
  logic               ret_v_q, ret_v_d;
  logic [SWEEP_W-1:0] ret_idx_q;
  logic               hdr_ok_q, hdr_ok_d;
  logic [47:0]        words_q, words_d;
  logic               rd_en;
  logic [7:0]         rd_data;

  assign rd_en = busy_q && (iss_q != SWEEP_W'(PARSE_BYTES));

  msp_ram #(
    .WIDTH(8),
    .DEPTH(REPLY_LENGTH)
  ) u_buf (
    .clk_i  (clk_i),
    .we_i   (wr_en_i),
    .waddr_i(wr_addr_i),
    .wdata_i(wr_data_i),
    .re_i   (rd_en),
    .raddr_i(AW'(iss_q)),
    .rdata_o(rd_data)
  );

  always_comb begin
    busy_d   = busy_q;
    done_d   = done_q;
    iss_d    = iss_q;
    ret_v_d  = rd_en;
    hdr_ok_d = hdr_ok_q;
    words_d  = words_q;
    if (rd_en) begin
      iss_d = iss_q + SWEEP_W'(1);
    end
    if (busy_q && !rd_en) begin
      busy_d = 1'b0;
    end
    // fold returned bytes into the header check or the word register
    if (ret_v_q) begin
      if (ret_idx_q < SWEEP_W'(HDR_BYTES)) begin
        hdr_ok_d = hdr_ok_q && (rd_data == hdr_byte(ret_idx_q));
      end else begin
        words_d = {words_q[39:0], rd_data};
      end
      if (ret_idx_q == SWEEP_W'(PARSE_BYTES - 1)) begin
        done_d = 1'b1;
      end
    end
    if (start_i) begin
      busy_d   = 1'b1;
      done_d   = 1'b0;
      iss_d    = '0;
      hdr_ok_d = 1'b1;
    end
    if (abort_i) begin
      busy_d  = 1'b0;
      done_d  = 1'b0;
      ret_v_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q  <= 1'b0;
      done_q  <= 1'b0;
      iss_q   <= '0;
      ret_v_q <= 1'b0;
    end else begin
      busy_q  <= busy_d;
      done_q  <= done_d;
      iss_q   <= iss_d;
      ret_v_q <= ret_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ret_idx_q <= iss_q;
    hdr_ok_q  <= hdr_ok_d;
    words_q   <= words_d;
  end

  assign sum_o.done     = done_q;
  assign sum_o.hdr_ok   = hdr_ok_q;
  assign sum_o.words[0] = words_q[47:32];
  assign sum_o.words[1] = words_q[31:16];
  assign sum_o.words[2] = words_q[15:0];

endmodule
`default_nettype wire

// ----- sv/msp_tx.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// msp_tx
// Two-entry result queue; a burst entry expands into the request frame.
// ----------------------------------------------------------------------------
module msp_tx (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                push_i,
  input  wire msp_pkg::res_desc_t  desc_i,
  output      logic                full_o,
  output      logic                out_valid_o,
  input  wire logic                out_stall_i,
  output      msp_pkg::out_item_t  out_data_o
);
  import msp_pkg::*;

  res_desc_t         ent_q [2];
  logic              head_q;
  logic [1:0]        cnt_q;
  logic [BEAT_W-1:0] beat_q;
  res_desc_t         head;
  logic              is_last;
  logic              xfer;
  logic              pop;
  logic              tail;

  assign head    = ent_q[head_q];
  assign is_last = !head.burst || (beat_q == BEAT_W'(FRAME_LEN - 1));
  assign xfer    = out_valid_o && !out_stall_i;
  assign pop     = xfer && is_last;
  assign tail    = head_q ^ (cnt_q == 2'd1);

  assign out_valid_o = (cnt_q != 2'd0);
  assign full_o      = (cnt_q == 2'd2);

  always_comb begin
    out_data_o.tx_valid           = head.burst;
    out_data_o.tx_byte            = head.burst ? frame_byte(beat_q) : 8'h00;
    out_data_o.last               = is_last;
    out_data_o.fsm_state          = head.fsm_state;
    out_data_o.data_ok            = head.data_ok;
    out_data_o.humidity_tenths    = head.words[0];
    out_data_o.temperature_tenths = head.words[1];
    out_data_o.conductivity       = head.words[2];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q <= 1'b0;
      cnt_q  <= 2'd0;
      beat_q <= '0;
    end else begin
      // advance through the frame, drop the entry on its final transfer
      if (pop) begin
        head_q <= ~head_q;
        beat_q <= '0;
      end else if (xfer) begin
        beat_q <= beat_q + BEAT_W'(1);
      end
      cnt_q <= cnt_q + {1'b0, push_i} - {1'b0, pop};
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      ent_q[tail] <= desc_i;
    end
  end

endmodule
`default_nettype wire

// ----- sv/modbus_sensor_poll_fsm_top.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// modbus_sensor_poll_fsm_top
// Modbus RTU read-holding-registers master that polls one sensor.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i / in_stall_o / in_data_i) carries one event per
//   transfer: tick, poll request, received byte, status read or restart.
//   Output channel (out_valid_o / out_stall_i / out_data_o) returns results:
//   eight transfers (the request frame, last on the eighth) for a tick that
//   sends, one transfer for every other event.
//   The result of an event is registered into the result queue when its input
//   transfers and offered once it reaches the head. Throughput is one event
//   per cycle while the queue has room and no parse waits on the sweep.
//   A two-entry result queue sits between the sides, so input keeps flowing
//   while a result waits; when the receiver stalls, the queue fills and
//   in_stall_o rises until an entry drains.
//   Reply bytes sit in a small RAM. Once the reply is complete a sweep reads
//   the nine header/data bytes; any event that arrives in the parsing phase
//   before the sweep finishes is held by in_stall_o.
//   Reset leaves the master idle with cleared readings, timeout at 500.
//   timeout_ticks is written over the APB port at byte address 0.
// ----------------------------------------------------------------------------
module modbus_sensor_poll_fsm_top #(
  parameter int unsigned REPLY_LENGTH = msp_pkg::REPLY_LENGTH_DEF
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          in_valid_i,
  output      logic                          in_stall_o,
  input  wire msp_pkg::in_item_t             in_data_i,
  output      logic                          out_valid_o,
  input  wire logic                          out_stall_i,
  output      msp_pkg::out_item_t            out_data_o,
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [msp_pkg::PADDR_W-1:0]   paddr,
  input  wire logic [31:0]                   pwdata,
  output      logic [31:0]                   prdata,
  output      logic                          pready
);
  import msp_pkg::*;

  localparam int unsigned AW = $clog2(REPLY_LENGTH);
  localparam int unsigned CW = $clog2(REPLY_LENGTH + 1);

  typedef enum logic [2:0] {
    PH_INIT  = 3'd0,
    PH_IDLE  = 3'd1,
    PH_REQ   = 3'd2,
    PH_WAIT  = 3'd3,
    PH_PARSE = 3'd4,
    PH_DONE  = 3'd5,
    PH_ERR   = 3'd6
  } phase_e;

  phase_e           phase_q, phase_d;
  logic [CW-1:0]    count_q, count_d;
  logic [15:0]      wait_q, wait_d;
  logic             valid_q, valid_d;
  logic [2:0][15:0] rd_q, rd_d;
  logic [15:0]      timeout_q;

  logic             acc;
  logic             queue_full;
  logic             push;
  res_desc_t        desc;
  reply_sum_t       sum;
  logic             wr_en;
  logic             sweep_start;
  logic             sweep_abort;
  logic [CW-1:0]    cnt_inc;
  logic [15:0]      wait_inc;
  logic             cfg_wr;

  // Hold input while the queue is full or a parse waits on the sweep
  assign in_stall_o = queue_full || ((phase_q == PH_PARSE) && !sum.done);
  assign acc        = in_valid_i && !in_stall_o;
  assign push       = acc;

  assign cnt_inc  = count_q + CW'(1);
  assign wait_inc = (wait_q != 16'hFFFF) ? (wait_q + 16'd1) : wait_q;

  // Configuration port
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && (paddr[2] == REG_TIMEOUT);
  assign prdata = (paddr[2] == REG_TIMEOUT) ? {16'h0000, timeout_q} : 32'h0;

  always_comb begin
    phase_d     = phase_q;
    count_d     = count_q;
    wait_d      = wait_q;
    valid_d     = valid_q;
    rd_d        = rd_q;
    wr_en       = 1'b0;
    sweep_start = 1'b0;
    sweep_abort = 1'b0;
    desc.burst  = 1'b0;

    if (acc) begin
      case (in_data_i.func)
        FUNC_TICK: begin
          case (phase_q)
            PH_INIT: begin
              valid_d = 1'b0;
              count_d = '0;
              phase_d = PH_IDLE;
            end
            PH_REQ: begin
              if (in_data_i.tx_refused) begin
                phase_d = PH_ERR;
              end else begin
                // send the frame, restart reply collection
                wait_d      = '0;
                count_d     = '0;
                phase_d     = PH_WAIT;
                desc.burst  = 1'b1;
                sweep_abort = 1'b1;
              end
            end
            PH_WAIT: begin
              if (count_q >= CW'(REPLY_LENGTH)) begin
                phase_d = PH_PARSE;
              end else begin
                wait_d = wait_inc;
                if (wait_inc >= timeout_q) begin
                  phase_d = PH_ERR;
                end
              end
            end
            PH_PARSE: begin
              if (sum.hdr_ok) begin
                rd_d    = sum.words;
                valid_d = 1'b1;
                phase_d = PH_DONE;
              end else begin
                phase_d = PH_ERR;
              end
            end
            PH_ERR: begin
              phase_d = PH_INIT;
            end
            default: begin
            end
          endcase
        end
        FUNC_REQUEST: begin
          if (phase_q inside {PH_IDLE, PH_DONE}) begin
            phase_d = PH_REQ;
          end
        end
        FUNC_BYTE: begin
          if ((phase_q == PH_WAIT) && (count_q < CW'(REPLY_LENGTH))) begin
            wr_en   = 1'b1;
            count_d = cnt_inc;
            if (cnt_inc == CW'(REPLY_LENGTH)) begin
              sweep_start = 1'b1;
            end
          end
        end
        FUNC_STATUS: begin
          if (phase_q == PH_DONE) begin
            phase_d = PH_IDLE;
          end
        end
        FUNC_RESTART: begin
          count_d = '0;
          phase_d = PH_INIT;
        end
        default: begin
        end
      endcase
    end

    // A status read reports the phase it saw; everything else the new one
    desc.fsm_state = (in_data_i.func == FUNC_STATUS) ? phase_q : phase_d;
    desc.data_ok   = valid_d;
    desc.words     = rd_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= PH_IDLE;
      count_q   <= '0;
      wait_q    <= '0;
      valid_q   <= 1'b0;
      rd_q      <= '0;
      timeout_q <= TIMEOUT_RESET;
    end else begin
      phase_q <= phase_d;
      count_q <= count_d;
      wait_q  <= wait_d;
      valid_q <= valid_d;
      rd_q    <= rd_d;
      if (cfg_wr) begin
        timeout_q <= pwdata[15:0];
      end
    end
  end

  msp_reply #(
    .REPLY_LENGTH(REPLY_LENGTH)
  ) u_reply (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .wr_en_i  (wr_en),
    .wr_addr_i(AW'(count_q)),
    .wr_data_i(in_data_i.rx_byte),
    .start_i  (sweep_start),
    .abort_i  (sweep_abort),
    .sum_o    (sum)
  );

  msp_tx u_tx (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .desc_i     (desc),
    .full_o     (queue_full),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o)
  );

endmodule
`default_nettype wire

// ----- dv/tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the sensor poll master: drive event transfers with
// random gaps, stall the result side at random, predict each result from a
// cycle-free model of the poll sequence and compare field by field.
// ----------------------------------------------------------------------------
module tb;
  import msp_pkg::*;

  localparam int unsigned REPLY_LEN    = REPLY_LENGTH_DEF;
  localparam int unsigned SETTLE       = 16;     // cycles to let the sweep finish
  localparam int unsigned STALL_LIMIT  = 3000;   // cycles without any transfer
  localparam logic [63:0] POLL_FRAME   = 64'h0103_0000_0003_05CB;
  localparam logic [PADDR_W-1:0] TIMEOUT_ADDR = {REG_TIMEOUT, 2'b00};

  // Poll phases as the block reports them
  typedef enum logic [2:0] {
    FSM_INIT  = 3'd0,
    FSM_IDLE  = 3'd1,
    FSM_REQ   = 3'd2,
    FSM_WAIT  = 3'd3,
    FSM_PARSE = 3'd4,
    FSM_DONE  = 3'd5,
    FSM_ERR   = 3'd6
  } fsm_phase_e;

  // --------------------------------------------------------------------------
  // Scoreboard: tracks the poll master's state and the queue of results
  // still owed on the output channel.
  // --------------------------------------------------------------------------
  class poll_scoreboard;
    fsm_phase_e  phase;
    logic [7:0]  reply [REPLY_LEN];
    int unsigned reply_cnt;
    logic [15:0] wait_cnt;
    logic [15:0] timeout;
    logic        data_ok;
    logic [15:0] humidity;
    logic [15:0] temperature;
    logic [15:0] conductivity;
    out_item_t   owed [$];
    int unsigned errors;

    function new();
      phase        = FSM_IDLE;
      reply_cnt    = 0;
      wait_cnt     = '0;
      timeout      = TIMEOUT_RESET;
      data_ok      = 1'b0;
      humidity     = '0;
      temperature  = '0;
      conductivity = '0;
      errors       = 0;
      foreach (reply[i]) reply[i] = '0;
    endfunction

    function void set_timeout(input logic [15:0] value);
      timeout = value;
    endfunction

    function int unsigned pending();
      return owed.size();
    endfunction

    function void owe(input logic txv, input logic [7:0] txb, input logic lst,
                      input fsm_phase_e st);
      out_item_t r;
      r.tx_valid           = txv;
      r.tx_byte            = txb;
      r.last               = lst;
      r.fsm_state          = st;
      r.data_ok            = data_ok;
      r.humidity_tenths    = humidity;
      r.temperature_tenths = temperature;
      r.conductivity       = conductivity;
      owed.push_back(r);
    endfunction

    function void tick(input logic refused);
      case (phase)
        FSM_INIT: begin
          data_ok   = 1'b0;
          reply_cnt = 0;
          phase     = FSM_IDLE;
        end
        FSM_REQ: begin
          if (refused) begin
            phase = FSM_ERR;
          end else begin
            wait_cnt  = '0;
            reply_cnt = 0;
            phase     = FSM_WAIT;
            for (int i = 0; i < 8; i++)
              owe(1'b1, POLL_FRAME[63-8*i -: 8], i == 7, phase);
            return;
          end
        end
        FSM_WAIT: begin
          if (reply_cnt >= REPLY_LEN) begin
            phase = FSM_PARSE;
          end else begin
            if (wait_cnt != 16'hFFFF) wait_cnt = wait_cnt + 16'd1;
            if (wait_cnt >= timeout) phase = FSM_ERR;
          end
        end
        FSM_PARSE: begin
          if (reply[0] == HDR_ADDR && reply[1] == HDR_FUNC && reply[2] == HDR_BCNT) begin
            humidity     = {reply[3], reply[4]};
            temperature  = {reply[5], reply[6]};
            conductivity = {reply[7], reply[8]};
            data_ok      = 1'b1;
            phase        = FSM_DONE;
          end else begin
            phase = FSM_ERR;
          end
        end
        FSM_ERR: phase = FSM_INIT;
        default: ;
      endcase
      owe(1'b0, 8'h00, 1'b1, phase);
    endfunction

    // Advance the model by one accepted event and queue what it owes
    function void note_input(input in_item_t ev);
      fsm_phase_e seen;
      case (ev.func)
        FUNC_TICK: begin
          tick(ev.tx_refused);
          return;
        end
        FUNC_REQUEST: if (phase == FSM_IDLE || phase == FSM_DONE) phase = FSM_REQ;
        FUNC_BYTE: begin
          if (phase == FSM_WAIT && reply_cnt < REPLY_LEN) begin
            reply[reply_cnt] = ev.rx_byte;
            reply_cnt++;
          end
        end
        FUNC_STATUS: begin
          seen = phase;
          if (phase == FSM_DONE) phase = FSM_IDLE;
          owe(1'b0, 8'h00, 1'b1, seen);
          return;
        end
        FUNC_RESTART: begin
          reply_cnt = 0;
          phase     = FSM_INIT;
        end
        default: ;
      endcase
      owe(1'b0, 8'h00, 1'b1, phase);
    endfunction

    function void cmp_field(input string name, input logic [15:0] want,
                            input logic [15:0] got);
      if (got !== want) begin
        $error("%s mismatch: expected 0x%0h, got 0x%0h", name, want, got);
        errors++;
      end
    endfunction

    function void check_result(input out_item_t got);
      out_item_t want;
      if (owed.size() == 0) begin
        $error("result with nothing owed: 0x%0h", got);
        errors++;
        return;
      end
      want = owed.pop_front();
      cmp_field("tx_valid", want.tx_valid, got.tx_valid);
      cmp_field("tx_byte", want.tx_byte, got.tx_byte);
      cmp_field("last", want.last, got.last);
      cmp_field("fsm_state", want.fsm_state, got.fsm_state);
      cmp_field("data_ok", want.data_ok, got.data_ok);
      cmp_field("humidity_tenths", want.humidity_tenths, got.humidity_tenths);
      cmp_field("temperature_tenths", want.temperature_tenths, got.temperature_tenths);
      cmp_field("conductivity", want.conductivity, got.conductivity);
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // Signals
  // --------------------------------------------------------------------------
  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               in_valid_i = 1'b0;
  logic               in_stall_o;
  in_item_t           in_data_i = '0;
  logic               out_valid_o;
  logic               out_stall_i = 1'b0;
  out_item_t          out_data_o;
  logic               psel = 1'b0;
  logic               penable = 1'b0;
  logic               pwrite = 1'b0;
  logic [PADDR_W-1:0] paddr = '0;
  logic [31:0]        pwdata = '0;
  logic [31:0]        prdata;
  logic               pready;

  poll_scoreboard sb = new();
  int unsigned    n_sent = 0;
  int unsigned    quiet_cycles = 0;
  bit             quiet_in = 1'b0;   // no input gaps while set

  modbus_sensor_poll_fsm_top u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // --------------------------------------------------------------------------
  // Result side: check every output transfer against the oldest owed result.
  // The result of an event shows up no earlier than the cycle after its own input
  // transfer, so the order of this block and the driver within a step is moot.
  // --------------------------------------------------------------------------
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) sb.check_result(out_data_o);
  end

  // Watchdog: end the run when no transfer happens on either side for too long
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
        $display("TEST FAILED");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  // Receiver stalls: mostly short bursts, a few long ones, and stretches of
  // free flow so that back-to-back results also get through.
  initial begin
    int unsigned run;
    int unsigned hold;
    @(posedge rst_ni);
    forever begin
      if ($urandom_range(0, 4) == 0) run = $urandom_range(30, 80);
      else run = $urandom_range(0, 4);
      repeat (run) begin
        @(negedge clk_i);
        out_stall_i = 1'b0;
      end
      if ($urandom_range(0, 9) == 0) hold = $urandom_range(10, 40);
      else hold = $urandom_range(1, 3);
      repeat (hold) begin
        @(negedge clk_i);
        out_stall_i = 1'b1;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Drivers
  // --------------------------------------------------------------------------
  function automatic int unsigned pick_gap();
    int unsigned r;
    if (quiet_in) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 96) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Offer one event after a random gap and hold it until the transfer
  task automatic send_event(input logic [2:0] f, input logic [7:0] b, input logic refused);
    in_item_t    ev;
    int unsigned gap;
    ev.func       = f;
    ev.rx_byte    = b;
    ev.tx_refused = refused;
    gap = pick_gap();
    @(negedge clk_i);
    repeat (gap) begin
      in_valid_i = 1'b0;
      @(negedge clk_i);
    end
    in_data_i  = ev;
    in_valid_i = 1'b1;
    do @(posedge clk_i); while (in_stall_o);
    sb.note_input(ev);
    n_sent++;
  endtask

  task automatic send_noise();
    send_event(3'($urandom_range(0, 7)), 8'($urandom_range(0, 255)),
               1'($urandom_range(0, 1)));
  endtask

  task automatic tick(input logic refused);
    send_event(FUNC_TICK, 8'($urandom_range(0, 255)), refused);
  endtask

  // Drop valid and wait until every owed result is back and the block is quiet
  task automatic drain();
    @(negedge clk_i);
    in_valid_i = 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  // Write the timeout register over APB, then read it back
  task automatic program_timeout(input logic [15:0] value);
    @(negedge clk_i);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = 1'b1;
    paddr   = TIMEOUT_ADDR;
    pwdata  = {16'h0000, value};
    @(negedge clk_i);
    penable = 1'b1;
    do @(posedge clk_i); while (!pready);
    sb.set_timeout(value);
    @(negedge clk_i);
    penable = 1'b0;
    pwrite  = 1'b0;
    @(negedge clk_i);
    penable = 1'b1;
    do @(posedge clk_i); while (!pready);
    if (prdata !== {16'h0000, sb.timeout}) begin
      $error("timeout_ticks readback mismatch: expected 0x%0h, got 0x%0h",
             sb.timeout, prdata);
      sb.errors++;
    end
    @(negedge clk_i);
    psel    = 1'b0;
    penable = 1'b0;
  endtask

  // One poll with random reply content. Most replies are well formed so
  // that parsing and the readings get exercised; some are short, long,
  // corrupted, cut by a restart or refused by the transmitter.
  task automatic poll_cycle();
    int unsigned nbytes;
    int unsigned cut;
    int unsigned sel;
    int unsigned bad_idx;
    bit          bad_hdr;
    bit          mix_ticks;
    logic [7:0]  b;
    quiet_in = ($urandom_range(0, 3) == 0);
    repeat ($urandom_range(0, 2)) send_noise();
    // bring the master back to a state that takes a request
    if (sb.phase != FSM_IDLE && sb.phase != FSM_DONE) begin
      send_event(FUNC_RESTART, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
      tick(1'($urandom_range(0, 1)));
    end
    send_event(FUNC_REQUEST, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
    tick($urandom_range(0, 7) == 0);
    sel = $urandom_range(0, 9);
    if (sel == 0) nbytes = $urandom_range(3, REPLY_LEN - 1);
    else if (sel == 1) nbytes = REPLY_LEN + $urandom_range(1, 2);
    else nbytes = REPLY_LEN;
    bad_hdr   = ($urandom_range(0, 5) == 0);
    bad_idx   = $urandom_range(0, HDR_BYTES - 1);
    mix_ticks = ($urandom_range(0, 1) == 1);
    cut       = ($urandom_range(0, 11) == 0) ? $urandom_range(0, nbytes - 1) : nbytes;
    for (int unsigned i = 0; i < nbytes; i++) begin
      if (i == cut)
        send_event(FUNC_RESTART, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
      if (mix_ticks && $urandom_range(0, 5) == 0) tick(1'($urandom_range(0, 1)));
      case (i)
        0:       b = HDR_ADDR;
        1:       b = HDR_FUNC;
        2:       b = HDR_BCNT;
        default: b = 8'($urandom_range(0, 255));
      endcase
      if (bad_hdr && i == bad_idx) b = b ^ 8'($urandom_range(1, 255));
      send_event(FUNC_BYTE, b, 1'($urandom_range(0, 1)));
    end
    // parse, finish, read status, and recover from an error if there was one
    tick(1'($urandom_range(0, 1)));
    tick(1'($urandom_range(0, 1)));
    send_event(FUNC_STATUS, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
    tick(1'($urandom_range(0, 1)));
  endtask

  task automatic run_polls(input int unsigned quota);
    int unsigned start;
    start = n_sent;
    while (n_sent - start < quota) poll_cycle();
  endtask

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Reset value first: readback must show the default timeout
    program_timeout(TIMEOUT_RESET);

    // Directed pass: odd events in idle, refused send, a clean poll with
    // extreme reading words, a byte past a full reply, and a restart.
    quiet_in = 1'b1;
    send_event(FUNC_STATUS, 8'h00, 1'b0);      // status read while not done
    send_event(FUNC_BYTE, 8'hFF, 1'b1);        // byte outside waiting
    send_event(3'd5, 8'h00, 1'b0);             // unknown codes
    send_event(3'd6, 8'hFF, 1'b1);
    send_event(3'd7, 8'h5A, 1'b0);
    send_event(FUNC_REQUEST, 8'h00, 1'b0);
    send_event(FUNC_REQUEST, 8'h00, 1'b0);     // request outside idle or done
    send_event(FUNC_TICK, 8'h00, 1'b1);        // transmitter refuses
    send_event(FUNC_TICK, 8'hFF, 1'b0);        // error to init
    send_event(FUNC_TICK, 8'h00, 1'b0);        // init to idle
    send_event(FUNC_REQUEST, 8'hFF, 1'b1);
    send_event(FUNC_TICK, 8'h00, 1'b0);        // request frame goes out
    send_event(FUNC_BYTE, HDR_ADDR, 1'b0);
    send_event(FUNC_BYTE, HDR_FUNC, 1'b1);
    send_event(FUNC_BYTE, HDR_BCNT, 1'b0);
    send_event(FUNC_BYTE, 8'h00, 1'b0);
    send_event(FUNC_BYTE, 8'h00, 1'b0);
    send_event(FUNC_BYTE, 8'hFF, 1'b0);
    send_event(FUNC_BYTE, 8'hFF, 1'b0);
    send_event(FUNC_BYTE, 8'h12, 1'b0);
    send_event(FUNC_BYTE, 8'h34, 1'b0);
    send_event(FUNC_BYTE, 8'hAB, 1'b0);
    send_event(FUNC_BYTE, 8'hCD, 1'b0);
    send_event(FUNC_BYTE, 8'hEE, 1'b0);        // reply already full
    send_event(FUNC_TICK, 8'h00, 1'b0);        // waiting to parsing
    send_event(FUNC_TICK, 8'h00, 1'b0);        // parsing to done
    send_event(FUNC_STATUS, 8'h00, 1'b0);      // done back to idle
    send_event(FUNC_RESTART, 8'h00, 1'b0);
    drain();

    // Longest timeout: replies always make it
    program_timeout(16'hFFFF);
    run_polls(25);
    drain();

    // Shortest timeout: any tick before a full reply errors
    program_timeout(16'd1);
    run_polls(15);
    drain();

    // Zero timeout behaves like the shortest one
    program_timeout(16'd0);
    run_polls(10);
    drain();

    // Small random timeouts so that ticks mixed into replies hit both ways
    program_timeout(16'($urandom_range(2, 20)));
    run_polls(15);
    drain();
    program_timeout(16'($urandom_range(2, 20)));
    run_polls(15);
    drain();

    if (sb.pending() != 0) begin
      $error("%0d results never arrived", sb.pending());
      sb.errors++;
    end
    if (sb.errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
